/* sv/skt_pkg.sv */
// shared types, constants and helpers for the k-th largest tracker
// no dependencies; used by every module of the block
package skt_pkg;

  localparam int unsigned MaxK  = 64;
  localparam int unsigned CntW  = $clog2(MaxK + 1);
  localparam int unsigned DataW = 16;
  localparam int unsigned RankW = 7;

  typedef logic [CntW-1:0]         count_t;
  typedef logic signed [DataW-1:0] data_t;
  typedef logic [RankW-1:0]        rank_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // item transfer: update the store and the result register
    logic clear;  // rank write: take the new rank and empty the store
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic store_full;  // k values currently held
  } dp_status_t;

  // rank zero acts as one, ranks above capacity act as capacity
  function automatic count_t eff_k(rank_t rank);
    int unsigned r;
    r = 32'(rank);
    if (r == 0) begin
      r = 1;
    end
    if (r > MaxK) begin
      r = MaxK;
    end
    return CntW'(r);
  endfunction

endpackage

/* sv/streaming_kth_largest_tracker_core.sv */
// top level of the streaming k-th largest tracker
// depends on skt_pkg, skt_ctrl and skt_datapath
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------
//   in       | input     | in_valid_i / in_stall_o  | sample_i (16b signed)
//   out      | output    | out_valid_o / out_stall_i| kth_value_o, full_res_o
//   cfg      | input     | cfg_we_i                 | cfg_wdata_i (rank, 7b)
//
// one item per cycle while the input is not stalled: the whole sorted row compares and shifts together,
// and the result is in the output register in the cycle after the transfer
// reset: rank 1, store empty, no result held
// a rank write empties the store at once; there is no clearing pass
// the input stalls only while a result is held and the output stalls
module streaming_kth_largest_tracker_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  skt_pkg::data_t       sample_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output skt_pkg::data_t       kth_value_o,
  output logic                 full_res_o,
  input  logic                 cfg_we_i,
  input  skt_pkg::rank_t       cfg_wdata_i
);

  skt_pkg::dp_cmd_t    cmd;
  skt_pkg::dp_status_t status;

  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  skt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .rank_wdata_i (cfg_wdata_i),
    .sample_i     (sample_i),
    .status_o     (status),
    .kth_value_o  (kth_value_o),
    .full_res_o   (full_res_o)
  );

endmodule

/* sv/skt_ctrl.sv */
// handshake controller: result register occupancy, stall and datapath commands
// depends on skt_pkg
module skt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic                cfg_we_i,
  input  skt_pkg::dp_status_t status_i,
  output skt_pkg::dp_cmd_t    cmd_o
);

  localparam logic StEmpty = 1'b0;
  localparam logic StHold  = 1'b1;

  logic state_q, state_d;
  logic accept;

  // a new item may enter whenever the held result leaves in the same cycle
  assign in_stall_o  = (state_q == StHold) && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == StHold);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StEmpty: begin
        if (accept) begin
          state_d = StHold;
        end
      end
      StHold: begin
        if (accept) begin
          state_d = StHold;
        end else if (!out_stall_i) begin
          state_d = StEmpty;
        end
      end
      default: state_d = StEmpty;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StEmpty;
    end else begin
      state_q <= state_d;
    end
  end

  // status is informational here; the store decides its own update
  logic unused_status;
  assign unused_status = status_i.store_full;

  always_comb begin
    cmd_o.load  = accept;
    cmd_o.clear = cfg_we_i;
  end

endmodule

/* sv/skt_datapath.sv */
// sorted row of held values with parallel compare-and-shift insertion,
// rank register, fill count and result register; depends on skt_pkg
module skt_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  skt_pkg::dp_cmd_t     cmd_i,
  input  skt_pkg::rank_t       rank_wdata_i,
  input  skt_pkg::data_t       sample_i,
  output skt_pkg::dp_status_t  status_o,
  output skt_pkg::data_t       kth_value_o,
  output logic                 full_res_o
);

  localparam int unsigned N = skt_pkg::MaxK;

  skt_pkg::rank_t  rank_q;
  skt_pkg::count_t count_q, count_d;
  skt_pkg::count_t k_eff;
  skt_pkg::data_t  cell_q [N];
  skt_pkg::data_t  cell_d [N];
  skt_pkg::data_t  kth_q, kth_d;
  logic            full_q, full_d;

  logic [N-1:0] keep;   // cell stays put when inserting while filling
  logic [N-1:0] keepw;  // cell takes its upper neighbour when replacing the minimum
  logic         store_full;
  logic         replace;
  logic         cell_we;

  assign k_eff      = skt_pkg::eff_k(rank_q);
  assign store_full = (count_q >= k_eff);
  assign replace    = store_full && (cell_q[0] < sample_i);
  assign cell_we    = cmd_i.load && (!store_full || replace);
  assign status_o.store_full = store_full;

  for (genvar i = 0; i < N; i++) begin : g_flag
    assign keep[i] = (skt_pkg::CntW'(i) < count_q) && !(cell_q[i] > sample_i);
    if (i < N - 1) begin : g_up
      assign keepw[i] = (skt_pkg::CntW'(i + 1) < count_q) && !(cell_q[i+1] > sample_i);
    end else begin : g_top
      assign keepw[i] = 1'b0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      if (N > 1) begin : g_multi
        always_comb begin
          if (!store_full) begin
            cell_d[i] = keep[i] ? cell_q[i] : sample_i;
          end else begin
            cell_d[i] = keepw[i] ? cell_q[i+1] : sample_i;
          end
        end
      end else begin : g_single
        always_comb begin
          cell_d[i] = keep[i] ? cell_q[i] : sample_i;
        end
      end
    end else if (i < N - 1) begin : g_mid
      always_comb begin
        if (!store_full) begin
          if (keep[i]) begin
            cell_d[i] = cell_q[i];
          end else if (keep[i-1]) begin
            cell_d[i] = sample_i;
          end else begin
            cell_d[i] = cell_q[i-1];
          end
        end else begin
          if (keepw[i]) begin
            cell_d[i] = cell_q[i+1];
          end else if (keepw[i-1]) begin
            cell_d[i] = sample_i;
          end else begin
            cell_d[i] = cell_q[i];
          end
        end
      end
    end else begin : g_last
      always_comb begin
        if (!store_full) begin
          if (keep[i]) begin
            cell_d[i] = cell_q[i];
          end else if (keep[i-1]) begin
            cell_d[i] = sample_i;
          end else begin
            cell_d[i] = cell_q[i-1];
          end
        end else begin
          cell_d[i] = keepw[i-1] ? sample_i : cell_q[i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (cell_we) begin
        cell_q[i] <= cell_d[i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.load && !store_full) begin
      count_d = count_q + skt_pkg::CntW'(1);
    end
  end

  always_comb begin
    kth_d  = cell_we ? cell_d[0] : cell_q[0];
    full_d = store_full || ((count_q + skt_pkg::CntW'(1)) == k_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q  <= skt_pkg::RankW'(1);
      count_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        rank_q <= rank_wdata_i;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kth_q  <= kth_d;
      full_q <= full_d;
    end
  end

  assign kth_value_o = kth_q;
  assign full_res_o  = full_q;

endmodule

/* sv/skt_checker.sv */
// port-level checks for the k-th largest tracker, bound to the top level
// depends on skt_pkg and streaming_kth_largest_tracker_core
module skt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input skt_pkg::data_t sample_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input skt_pkg::data_t kth_value_o,
  input logic           full_res_o,
  input logic           cfg_we_i,
  input skt_pkg::rank_t cfg_wdata_i
);

  logic in_xfer;
  logic unused_sample;
  assign in_xfer       = in_valid_i && !in_stall_o;
  assign unused_sample = ^sample_i;

  // every input transfer leaves a result waiting
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("no result after input transfer");

  // input stalls only because a held result is being stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(kth_value_o) && $stable(full_res_o)))
    else $error("stalled result changed");

  // with rank one the first sample after the write already fills the store
  a_rank_one_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_wdata_i == 7'd0 || cfg_wdata_i == 7'd1) && !in_xfer)
      ##1 (in_xfer && !cfg_we_i) |=> full_res_o)
    else $error("rank one result not marked full");

endmodule

bind streaming_kth_largest_tracker_core skt_checker u_skt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .sample_i    (sample_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kth_value_o (kth_value_o),
  .full_res_o  (full_res_o),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i)
);
